// File: hdl/pcmh_pkg.sv
// shared types and constants of the max-height grid rasterizer
`default_nettype none
package pcmh_pkg;

    // request command codes
    localparam logic [1:0] CMD_ADD      = 2'd0;
    localparam logic [1:0] CMD_READ     = 2'd1;
    localparam logic [1:0] CMD_READ_CLR = 2'd2;

    // configuration register indexes
    localparam int         CFG_IDX_W         = 3;
    localparam logic [2:0] REG_MIN_X         = 3'd0;
    localparam logic [2:0] REG_MIN_Y         = 3'd1;
    localparam logic [2:0] REG_MIN_Z         = 3'd2;
    localparam logic [2:0] REG_INV_CELL_SIZE = 3'd3;
    localparam logic [2:0] REG_HEIGHT_SCALE  = 3'd4;
    localparam logic [2:0] REG_GRID_COLS     = 3'd5;
    localparam logic [2:0] REG_GRID_ROWS     = 3'd6;

    // saturation limits
    localparam logic [7:0] HEIGHT_MAX = 8'd255;
    localparam logic [8:0] IDX_MAX    = 9'd511;

    // decoupling queue
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [8:0]         read_col;
        logic [8:0]         read_row;
    } pcmh_req_t;

    typedef struct packed {
        logic [7:0] cell_height;
        logic       in_grid;
        logic       raised;
        logic [8:0] cell_col;
        logic [8:0] cell_row;
    } pcmh_rsp_t;

    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] min_z;
        logic [31:0]        inv_cell_size;
        logic [31:0]        height_scale;
        logic [9:0]         grid_cols;
        logic [9:0]         grid_rows;
    } pcmh_cfg_t;

    // classified request handed from front to back
    typedef struct packed {
        logic [1:0] cmd;
        logic       in_grid;
        logic [7:0] height;
        logic [8:0] col;
        logic [8:0] row;
    } pcmh_item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } pcmh_q_stat_t;

    typedef struct packed {
        logic clearing;
    } pcmh_bk_stat_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_UPDATE
    } pcmh_bk_state_t;

endpackage
`default_nettype wire

// File: hdl/pcmh_front.sv
// front end: index and height computation and request classification
`default_nettype none
module pcmh_front
    import pcmh_pkg::*;
#(
    parameter int MAX_COLS = 512,
    parameter int MAX_ROWS = 512,
    parameter int AW       = 18
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    input  wire pcmh_req_t  req,
    input  wire pcmh_cfg_t  cfg,
    input  wire logic       adv,
    output logic            push,
    output pcmh_item_t      item,
    output logic [AW-1:0]   addr
);

    localparam int          CW        = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int          RW        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam logic [31:0] COL_LIMIT = 32'(MAX_COLS);
    localparam logic [31:0] ROW_LIMIT = 32'(MAX_ROWS);

    // stage a: captured request
    logic       a_valid_reg;
    pcmh_req_t  a_req_reg;

    // stage b: offsets from the grid origin
    logic        b_valid_reg;
    logic [1:0]  b_cmd_reg;
    logic [32:0] b_dx_reg;
    logic [32:0] b_dy_reg;
    logic [32:0] b_dz_reg;
    logic [8:0]  b_rcol_reg;
    logic [8:0]  b_rrow_reg;

    // stage c: scaled products
    logic        c_valid_reg;
    logic [1:0]  c_cmd_reg;
    logic [31:0] c_colq_reg;
    logic        c_col_neg_reg;
    logic [31:0] c_rowq_reg;
    logic        c_row_neg_reg;
    logic [31:0] c_hq_reg;
    logic        c_h_zero_reg;
    logic [8:0]  c_rcol_reg;
    logic [8:0]  c_rrow_reg;

    logic [63:0] prod_x;
    logic [63:0] prod_y;
    logic [63:0] prod_z;

    assign prod_x = 64'(b_dx_reg[31:0]) * 64'(cfg.inv_cell_size);
    assign prod_y = 64'(b_dy_reg[31:0]) * 64'(cfg.inv_cell_size);
    assign prod_z = 64'(b_dz_reg[31:0]) * 64'(cfg.height_scale);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= req_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_req_reg     <= req;
            b_cmd_reg     <= a_req_reg.cmd;
            b_dx_reg      <= {a_req_reg.pos_x[31], a_req_reg.pos_x} - {cfg.min_x[31], cfg.min_x};
            b_dy_reg      <= {a_req_reg.pos_y[31], a_req_reg.pos_y} - {cfg.min_y[31], cfg.min_y};
            b_dz_reg      <= {a_req_reg.pos_z[31], a_req_reg.pos_z} - {cfg.min_z[31], cfg.min_z};
            b_rcol_reg    <= a_req_reg.read_col;
            b_rrow_reg    <= a_req_reg.read_row;
            c_cmd_reg     <= b_cmd_reg;
            c_colq_reg    <= prod_x[63:32];
            c_col_neg_reg <= b_dx_reg[32] && (cfg.inv_cell_size != 32'd0);
            c_rowq_reg    <= prod_y[63:32];
            c_row_neg_reg <= b_dy_reg[32] && (cfg.inv_cell_size != 32'd0);
            c_hq_reg      <= prod_z[63:32];
            c_h_zero_reg  <= b_dz_reg[32] || (b_dz_reg == 33'd0);
            c_rcol_reg    <= b_rcol_reg;
            c_rrow_reg    <= b_rrow_reg;
        end
    end

    // classification
    logic        is_add;
    logic        is_rd;
    logic [31:0] col_full;
    logic [31:0] row_full;
    logic        col_neg;
    logic        row_neg;
    logic        in_grid;

    always_comb
    begin
        is_add   = (c_cmd_reg == CMD_ADD);
        is_rd    = (c_cmd_reg == CMD_READ) || (c_cmd_reg == CMD_READ_CLR);
        col_full = is_add ? c_colq_reg : {23'd0, c_rcol_reg};
        row_full = is_add ? c_rowq_reg : {23'd0, c_rrow_reg};
        col_neg  = is_add && c_col_neg_reg;
        row_neg  = is_add && c_row_neg_reg;
        in_grid  = (is_add || is_rd) && !col_neg && !row_neg
                   && (col_full < {22'd0, cfg.grid_cols}) && (col_full < COL_LIMIT)
                   && (row_full < {22'd0, cfg.grid_rows}) && (row_full < ROW_LIMIT);

        item.cmd     = c_cmd_reg;
        item.in_grid = in_grid;

        if (!is_add || c_h_zero_reg)
            item.height = 8'd0;
        else if (c_hq_reg > 32'(HEIGHT_MAX))
            item.height = HEIGHT_MAX;
        else
            item.height = c_hq_reg[7:0];

        if (is_add)
        begin
            item.col = col_neg ? 9'd0 : (col_full > 32'(IDX_MAX)) ? IDX_MAX : col_full[8:0];
            item.row = row_neg ? 9'd0 : (row_full > 32'(IDX_MAX)) ? IDX_MAX : row_full[8:0];
        end
        else if (is_rd)
        begin
            item.col = c_rcol_reg;
            item.row = c_rrow_reg;
        end
        else
        begin
            item.col = 9'd0;
            item.row = 9'd0;
        end

        // row-major cell address, only meaningful inside the grid
        if (in_grid)
            addr = AW'(row_full[RW-1:0]) * AW'(MAX_COLS) + AW'(col_full[CW-1:0]);
        else
            addr = '0;

        push = c_valid_reg && adv;
    end

endmodule
`default_nettype wire

// File: hdl/pcmh_queue.sv
// small fifo between the front and back ends
`default_nettype none
module pcmh_queue
    import pcmh_pkg::*;
#(
    parameter int AW = 18
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire pcmh_item_t    push_item,
    input  wire logic [AW-1:0] push_addr,
    input  wire logic          pop,
    output pcmh_item_t         head_item,
    output logic [AW-1:0]      head_addr,
    output pcmh_q_stat_t       stat
);

    pcmh_item_t           item_mem_reg [Q_DEPTH];
    logic [AW-1:0]        addr_mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            item_mem_reg[wr_ptr_reg] <= push_item;
            addr_mem_reg[wr_ptr_reg] <= push_addr;
        end
    end

    assign head_item  = item_mem_reg[rd_ptr_reg];
    assign head_addr  = addr_mem_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == Q_CNT_W'(Q_DEPTH));

endmodule
`default_nettype wire

// File: hdl/pcmh_back.sv
// back end: height grid memory, clearing pass and read-modify-write
`default_nettype none
module pcmh_back
    import pcmh_pkg::*;
#(
    parameter int MAX_COLS = 512,
    parameter int MAX_ROWS = 512,
    parameter int AW       = 18
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire pcmh_item_t    head_item,
    input  wire logic [AW-1:0] head_addr,
    input  wire pcmh_q_stat_t  q_stat,
    output logic               pop,
    output pcmh_bk_stat_t      stat,
    output logic               done,
    output pcmh_rsp_t          rsp
);

    localparam int          DEPTH    = MAX_COLS * MAX_ROWS;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    logic [7:0]      height_grid_reg [DEPTH];
    logic [7:0]      rd_data_reg;

    pcmh_bk_state_t  state_reg;
    pcmh_bk_state_t  state_next;
    logic [AW-1:0]   clr_addr_reg;
    logic [AW-1:0]   clr_addr_next;
    pcmh_item_t      item_reg;
    logic [AW-1:0]   addr_reg;
    logic            done_reg;
    logic            done_next;
    pcmh_rsp_t       rsp_reg;
    pcmh_rsp_t       rsp_next;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [7:0]      mem_wdata;
    logic            raise;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_CLEAR;
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head_item;
            addr_reg <= head_addr;
        end
        rsp_reg <= rsp_next;
    end

    // grid memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            height_grid_reg[mem_waddr] <= mem_wdata;
        if (pop)
            rd_data_reg <= height_grid_reg[head_addr];
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        done_next     = 1'b0;
        rsp_next      = rsp_reg;
        pop           = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = addr_reg;
        mem_wdata     = 8'd0;
        raise         = item_reg.in_grid && (item_reg.height > rd_data_reg);

        case (state_reg)
            BK_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR)
                    state_next = BK_IDLE;
            end
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop        = 1'b1;
                    state_next = BK_UPDATE;
                end
            end
            BK_UPDATE:
            begin
                done_next            = 1'b1;
                rsp_next.in_grid     = item_reg.in_grid;
                rsp_next.cell_col    = item_reg.col;
                rsp_next.cell_row    = item_reg.row;
                rsp_next.raised      = 1'b0;
                rsp_next.cell_height = item_reg.in_grid ? rd_data_reg : 8'd0;
                case (item_reg.cmd)
                    CMD_ADD:
                    begin
                        if (raise)
                        begin
                            mem_we               = 1'b1;
                            mem_wdata            = item_reg.height;
                            rsp_next.raised      = 1'b1;
                            rsp_next.cell_height = item_reg.height;
                        end
                    end
                    CMD_READ:
                    begin
                    end
                    CMD_READ_CLR:
                    begin
                        mem_we = item_reg.in_grid;
                    end
                    default:
                    begin
                        rsp_next.cell_height = 8'd0;
                    end
                endcase
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign stat.clearing = (state_reg == BK_CLEAR);
    assign done          = done_reg;
    assign rsp           = rsp_reg;

endmodule
`default_nettype wire

// File: hdl/point_cloud_max_height_grid_top.sv
// top level of the point cloud max-height grid rasterizer
// an accepted request passes front stages a, b and c, the queue and the back end update state before its done strobe
// the back end pops a new request only after the grid memory read-modify-write of the last one
// the result shows for one cycle on done and cannot be stalled by the receiver
// reset: async active low; afterwards busy stays high while the grid is zeroed one cell a cycle
`default_nettype none
module point_cloud_max_height_grid_top
    import pcmh_pkg::*;
#(
    parameter int MAX_COLS = 512,
    parameter int MAX_ROWS = 512
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // request channel
    input  wire logic                 start,
    input  wire pcmh_req_t            req,
    output logic                      busy,
    // result channel
    output logic                      done,
    output pcmh_rsp_t                 rsp,
    // configuration write port
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    // address width of the cell memory
    localparam int AW = (MAX_COLS * MAX_ROWS > 1) ? $clog2(MAX_COLS * MAX_ROWS) : 1;

    // configuration registers
    pcmh_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_x         <= 32'sd0;
            cfg_reg.min_y         <= 32'sd0;
            cfg_reg.min_z         <= 32'sd0;
            cfg_reg.inv_cell_size <= 32'd65536;
            cfg_reg.height_scale  <= 32'd65536;
            cfg_reg.grid_cols     <= 10'd512;
            cfg_reg.grid_rows     <= 10'd512;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_X:         cfg_reg.min_x         <= cfg_data;
                REG_MIN_Y:         cfg_reg.min_y         <= cfg_data;
                REG_MIN_Z:         cfg_reg.min_z         <= cfg_data;
                REG_INV_CELL_SIZE: cfg_reg.inv_cell_size <= cfg_data;
                REG_HEIGHT_SCALE:  cfg_reg.height_scale  <= cfg_data;
                REG_GRID_COLS:     cfg_reg.grid_cols     <= cfg_data[9:0];
                REG_GRID_ROWS:     cfg_reg.grid_rows     <= cfg_data[9:0];
                default:
                begin
                end
            endcase
        end
    end

    // handshake between the parts
    pcmh_q_stat_t   q_stat;
    pcmh_bk_stat_t  bk_stat;
    logic           front_adv;
    logic           req_valid;
    logic           push;
    logic           pop;
    pcmh_item_t     push_item;
    logic [AW-1:0]  push_addr;
    pcmh_item_t     head_item;
    logic [AW-1:0]  head_addr;

    // front pipeline moves only while the queue has room
    assign front_adv = !q_stat.full;
    // no requests during the clearing pass or while the front is stalled
    assign busy      = bk_stat.clearing || !front_adv;
    assign req_valid = start && !busy;

    // front: offsets, scaling, saturation, bounds check and cell address
    pcmh_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .AW       (AW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .cfg       (cfg_reg),
        .adv       (front_adv),
        .push      (push),
        .item      (push_item),
        .addr      (push_addr)
    );

    // queue decouples classification from the memory update
    pcmh_queue #(
        .AW (AW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .push_addr (push_addr),
        .pop       (pop),
        .head_item (head_item),
        .head_addr (head_addr),
        .stat      (q_stat)
    );

    // back: grid memory, max update, read and read-and-clear
    pcmh_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .AW       (AW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_item (head_item),
        .head_addr (head_addr),
        .q_stat    (q_stat),
        .pop       (pop),
        .stat      (bk_stat),
        .done      (done),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire
